FILE: src/imu_cal_pkg.sv
// Shared types and constants of the IMU sample calibration block.
package imu_cal_pkg;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CORRECT = 1'b1
  } opcode_t;

  localparam int IDX_W     = 6;
  localparam int N_COEF    = 33;
  localparam int SLOT_AINV = 0;
  localparam int SLOT_BA   = 9;
  localparam int SLOT_GINV = 12;
  localparam int SLOT_BG   = 21;
  localparam int SLOT_TS   = 24;

  // Matrices are Q3.14; 1.0 needs 16 signed bits.
  localparam int Q_FRAC  = 14;
  localparam int Q_ONE   = 16384;
  localparam int Q_HALF  = 8192;
  localparam int Q_ONE_W = 16;

  // Vector operands into the multipliers are held to 31 signed bits.
  localparam int GUARD_W = 31;

endpackage

FILE: src/imu_cal_sat.sv
// Signed saturation from IW to OW bits, or sign extension when OW is not narrower.
module imu_cal_sat #(
  parameter int IW = 20,
  parameter int OW = 16
) (
  input  logic signed [IW-1:0] d,
  output logic signed [OW-1:0] q,
  output logic                 hit
);

  generate
    if (IW > OW) begin : g_clamp
      always_comb begin
        hit = (d[IW-1:OW-1] != {(IW-OW+1){d[IW-1]}});
        if (hit) begin
          q = {d[IW-1], {(OW-1){~d[IW-1]}}};
        end else begin
          q = d[OW-1:0];
        end
      end
    end else begin : g_ext
      assign q   = OW'(d);
      assign hit = 1'b0;
    end
  endgenerate

endmodule

FILE: src/imu_cal_row.sv
// One matrix row lane: three products, then sum and round half up to an integer.
module imu_cal_row #(
  parameter int  CW = 18,
  parameter int  VW = 17,
  localparam int RW = CW + VW + 2 - imu_cal_pkg::Q_FRAC
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] coef [3],
  input  logic signed [VW-1:0] vec  [3],
  output logic signed [RW-1:0] sum_o
);

  localparam int PW   = CW + VW;
  localparam int SUMW = PW + 2;

  logic signed [PW-1:0]   prod_r [3];
  logic signed [SUMW-1:0] sum;
  logic signed [RW-1:0]   sum_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= PW'(coef[k]) * PW'(vec[k]);
    end
    sum_r <= sum[SUMW-1:imu_cal_pkg::Q_FRAC];
  end

  assign sum = SUMW'(prod_r[0]) + SUMW'(prod_r[1]) + SUMW'(prod_r[2])
             + SUMW'(imu_cal_pkg::Q_HALF);

  assign sum_o = sum_r;

endmodule

FILE: src/imu_sample_calibration_top.sv
// Top level of the IMU sample calibration block: coefficient bank and lane pipeline.
//
// One input channel carries both coefficient loads and sample pairs. A word is
// taken at a rising edge where start is high and busy is low. With opcode load,
// the coefficient value is written to the slot named by coef_index (slots above
// 32 are dropped) and no result follows. With opcode correct, the accel vector
// is bias corrected and multiplied by the accel inverse matrix in three row lanes,
// then the g-sensitivity term (three more lanes) and the gyro bias are removed
// from the gyro vector, which goes through the gyro inverse matrix lanes.
// The row lanes round their sums, the accel and gyro inverse-matrix results are saturated
// to the sample width, and the output stage ORs their saturation flags into clipped. A result word
// is on the out_ ports for one cycle with out_valid high, after its sample pair has
// passed through all three lanes and the output registers. One word is taken every
// cycle while busy is low; the rate is set by the three chained two-stage multiplier
// lanes, which are fully pipelined. A load travels down the pipeline and updates each
// coefficient group at the stage that reads it, so every word sees exactly the loads
// taken before it. The receiver cannot stall the block. After reset the coefficient
// bank holds identity matrices and zero biases and sensitivity, and busy is high for the first cycle only.
module imu_sample_calibration_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_opcode,
  input  logic [imu_cal_pkg::IDX_W-1:0]        in_coef_index,
  input  logic signed [COEF_WIDTH-1:0]         in_coef_value,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_raw_accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_raw_accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_raw_accel_z,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_raw_gyro_x,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_raw_gyro_y,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_raw_gyro_z,
  output logic                                 out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]       out_fixed_accel_x,
  output logic signed [SAMPLE_WIDTH-1:0]       out_fixed_accel_y,
  output logic signed [SAMPLE_WIDTH-1:0]       out_fixed_accel_z,
  output logic signed [SAMPLE_WIDTH-1:0]       out_fixed_gyro_x,
  output logic signed [SAMPLE_WIDTH-1:0]       out_fixed_gyro_y,
  output logic signed [SAMPLE_WIDTH-1:0]       out_fixed_gyro_z,
  output logic                                 out_clipped
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int GW    = imu_cal_pkg::GUARD_W;
  localparam int IW    = imu_cal_pkg::IDX_W;
  // Coefficient storage is wide enough to hold 1.0 for the identity reset.
  localparam int CKW   = (COEF_WIDTH > imu_cal_pkg::Q_ONE_W) ? COEF_WIDTH
                                                             : imu_cal_pkg::Q_ONE_W;
  localparam int MAXSC = (SW > CKW) ? SW : CKW;
  localparam int DW    = MAXSC + 1;
  localparam int OW1   = (DW < GW) ? DW : GW;
  localparam int RA    = CKW + OW1 + 2 - imu_cal_pkg::Q_FRAC;
  localparam int AGW   = (SW < GW) ? SW : GW;
  localparam int RC    = CKW + AGW + 2 - imu_cal_pkg::Q_FRAC;
  localparam int EW    = ((MAXSC > RC) ? MAXSC : RC) + 2;
  localparam int OE    = (EW < GW) ? EW : GW;
  localparam int RG    = CKW + OE + 2 - imu_cal_pkg::Q_FRAC;

  logic accept;
  logic acc_ld;
  logic acc_cor;
  logic busy_r;

  logic [10:1] cor_r;
  logic [7:1]  ld_r;
  logic [IW-1:0]         idx_r [1:7];
  logic signed [CKW-1:0] val_r [1:7];

  logic signed [CKW-1:0] ainv_r [3][3];
  logic signed [CKW-1:0] ginv_r [3][3];
  logic signed [CKW-1:0] ts_r   [3][3];
  logic signed [CKW-1:0] ba_r   [3];
  logic signed [CKW-1:0] bg_r   [3];

  logic signed [SW-1:0]  raw_a  [3];
  logic signed [SW-1:0]  raw_g  [3];
  logic signed [DW-1:0]  dsub   [3];
  logic signed [OW1-1:0] d_c    [3];
  logic signed [OW1-1:0] d_r    [3];
  logic signed [SW-1:0]  rawg_r [1:6][3];

  logic signed [RA-1:0]  a_rnd  [3];
  logic signed [SW-1:0]  asat_c [3];
  logic [2:0]            hit_a;
  logic signed [AGW-1:0] ag_c   [3];
  logic signed [AGW-1:0] ag_r   [3];
  logic signed [SW-1:0]  asat_r [4:9][3];
  logic                  aclip_r [4:9];

  logic signed [RC-1:0]  c_rnd  [3];
  logic signed [EW-1:0]  e_c    [3];
  logic signed [OE-1:0]  e_s    [3];
  logic signed [OE-1:0]  e_r    [3];

  logic signed [RG-1:0]  g_rnd  [3];
  logic signed [SW-1:0]  gsat_c [3];
  logic [2:0]            hit_g;

  logic signed [SW-1:0]  acc_out_r [3];
  logic signed [SW-1:0]  gyr_out_r [3];
  logic                  clip_r;

  assign busy    = busy_r;
  assign accept  = start && !busy_r;
  assign acc_ld  = accept && (in_opcode == imu_cal_pkg::OP_LOAD);
  assign acc_cor = accept && (in_opcode == imu_cal_pkg::OP_CORRECT);

  assign raw_a[0] = in_raw_accel_x;
  assign raw_a[1] = in_raw_accel_y;
  assign raw_a[2] = in_raw_accel_z;
  assign raw_g[0] = in_raw_gyro_x;
  assign raw_g[1] = in_raw_gyro_y;
  assign raw_g[2] = in_raw_gyro_z;

  // Control pipeline: a bit per stage for correct words and for load words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cor_r  <= '0;
      ld_r   <= '0;
    end else begin
      busy_r <= 1'b0;
      cor_r  <= {cor_r[9:1], acc_cor};
      ld_r   <= {ld_r[6:1], acc_ld};
    end
  end

  // Coefficient bank. Each group is written when a load reaches the stage
  // that reads that group, which keeps loads in order with the samples.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        ba_r[r] <= CKW'(0);
        bg_r[r] <= CKW'(0);
        for (int c = 0; c < 3; c++) begin
          ainv_r[r][c] <= (r == c) ? CKW'(imu_cal_pkg::Q_ONE) : CKW'(0);
          ginv_r[r][c] <= (r == c) ? CKW'(imu_cal_pkg::Q_ONE) : CKW'(0);
          ts_r[r][c]   <= CKW'(0);
        end
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        if (acc_ld && in_coef_index == IW'(imu_cal_pkg::SLOT_BA + r)) begin
          ba_r[r] <= CKW'(in_coef_value);
        end
        if (ld_r[6] && idx_r[6] == IW'(imu_cal_pkg::SLOT_BG + r)) begin
          bg_r[r] <= val_r[6];
        end
        for (int c = 0; c < 3; c++) begin
          if (ld_r[1] && idx_r[1] == IW'(imu_cal_pkg::SLOT_AINV + 3 * r + c)) begin
            ainv_r[r][c] <= val_r[1];
          end
          if (ld_r[4] && idx_r[4] == IW'(imu_cal_pkg::SLOT_TS + 3 * r + c)) begin
            ts_r[r][c] <= val_r[4];
          end
          if (ld_r[7] && idx_r[7] == IW'(imu_cal_pkg::SLOT_GINV + 3 * r + c)) begin
            ginv_r[r][c] <= val_r[7];
          end
        end
      end
    end
  end

  // Per-lane datapath: accel bias removal, operand guards, row lanes and saturation.
  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_lane
      assign dsub[i] = DW'(raw_a[i]) - DW'(ba_r[i]);

      imu_cal_sat #(.IW(DW), .OW(OW1)) u_dguard (
        .d   (dsub[i]),
        .q   (d_c[i]),
        .hit ()
      );

      imu_cal_row #(.CW(CKW), .VW(OW1)) u_arow (
        .clk   (clk),
        .coef  (ainv_r[i]),
        .vec   (d_r),
        .sum_o (a_rnd[i])
      );

      imu_cal_sat #(.IW(RA), .OW(SW)) u_asat (
        .d   (a_rnd[i]),
        .q   (asat_c[i]),
        .hit (hit_a[i])
      );

      imu_cal_sat #(.IW(SW), .OW(AGW)) u_agguard (
        .d   (asat_c[i]),
        .q   (ag_c[i]),
        .hit ()
      );

      imu_cal_row #(.CW(CKW), .VW(AGW)) u_trow (
        .clk   (clk),
        .coef  (ts_r[i]),
        .vec   (ag_r),
        .sum_o (c_rnd[i])
      );

      assign e_c[i] = EW'(rawg_r[6][i]) - EW'(bg_r[i]) - EW'(c_rnd[i]);

      imu_cal_sat #(.IW(EW), .OW(OE)) u_eguard (
        .d   (e_c[i]),
        .q   (e_s[i]),
        .hit ()
      );

      imu_cal_row #(.CW(CKW), .VW(OE)) u_grow (
        .clk   (clk),
        .coef  (ginv_r[i]),
        .vec   (e_r),
        .sum_o (g_rnd[i])
      );

      imu_cal_sat #(.IW(RG), .OW(SW)) u_gsat (
        .d   (g_rnd[i]),
        .q   (gsat_c[i]),
        .hit (hit_g[i])
      );
    end
  endgenerate

  // Payload pipeline.
  always_ff @(posedge clk) begin
    idx_r[1] <= in_coef_index;
    val_r[1] <= CKW'(in_coef_value);
    for (int s = 2; s <= 7; s++) begin
      idx_r[s] <= idx_r[s-1];
      val_r[s] <= val_r[s-1];
    end
    for (int k = 0; k < 3; k++) begin
      d_r[k]       <= d_c[k];
      rawg_r[1][k] <= raw_g[k];
      for (int s = 2; s <= 6; s++) begin
        rawg_r[s][k] <= rawg_r[s-1][k];
      end
      ag_r[k]      <= ag_c[k];
      asat_r[4][k] <= asat_c[k];
      for (int s = 5; s <= 9; s++) begin
        asat_r[s][k] <= asat_r[s-1][k];
      end
      e_r[k]       <= e_s[k];
      acc_out_r[k] <= asat_r[9][k];
      gyr_out_r[k] <= gsat_c[k];
    end
    aclip_r[4] <= |hit_a;
    for (int s = 5; s <= 9; s++) begin
      aclip_r[s] <= aclip_r[s-1];
    end
    clip_r <= aclip_r[9] | (|hit_g);
  end

  assign out_valid         = cor_r[10];
  assign out_fixed_accel_x = acc_out_r[0];
  assign out_fixed_accel_y = acc_out_r[1];
  assign out_fixed_accel_z = acc_out_r[2];
  assign out_fixed_gyro_x  = gyr_out_r[0];
  assign out_fixed_gyro_y  = gyr_out_r[1];
  assign out_fixed_gyro_z  = gyr_out_r[2];
  assign out_clipped       = clip_r;

  // A taken sample pair always yields a result word.
  a_cor_result : assert property (@(posedge clk) disable iff (!rst_n)
    acc_cor |-> ##10 out_valid)
    else $error("sample pair produced no result word at the expected cycle");

  // A load never produces a result word.
  a_ld_silent : assert property (@(posedge clk) disable iff (!rst_n)
    acc_ld |-> ##10 !out_valid)
    else $error("load word produced a result word");

  // Once out of reset, busy stays low, so the block can take a word every cycle.
  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  // A stage holds either a load or a sample pair, never both.
  a_stage_excl : assert property (@(posedge clk) disable iff (!rst_n)
    (ld_r & cor_r[7:1]) == '0)
    else $error("load and sample pair share a pipeline stage");

endmodule
